// ----- hw/rtl/phm_pkg.sv -----
// phm_pkg: shared types and constants for the ping heartbeat monitor.
// No dependencies; used by phm_core and ping_heartbeat_monitor.
`default_nettype none

package phm_pkg;

	// Configuration register map
	localparam int CfgRegCount = 2;
	localparam int CfgIdxWidth = 1;
	localparam int CfgDataWidth = 16;
	localparam logic [CfgIdxWidth-1:0] CFG_REQ_INTERVAL  = 1'b0;
	localparam logic [CfgIdxWidth-1:0] CFG_REPLY_TIMEOUT = 1'b1;

	localparam logic [CfgDataWidth-1:0] PingIntervalReset = 16'd1000;
	localparam logic [CfgDataWidth-1:0] PingTimeoutReset  = 16'd4000;

	// Fixed field widths
	localparam int IdWidth = 32;
	localparam int CountWidth = 32;
	localparam int RttWidth = 32;
	localparam int FlagsMaxWidth = 32;

	// Parameter defaults
	localparam int TimeWidthDef = 32;
	localparam int FlagsWidthDef = 8;
	localparam int FullBitDef = 2;
	localparam int ReadyBitDef = 0;
	localparam int HasBeenReadyBitDef = 1;

	typedef enum logic [1:0] {
		KIND_INIT     = 2'd0,
		KIND_FAILED   = 2'd1,
		KIND_MEASURED = 2'd2
	} reading_kind_t;

	typedef enum logic [2:0] {
		STATUS_INIT   = 3'd0,
		STATUS_FAILED = 3'd1,
		STATUS_FULL   = 3'd2,
		STATUS_READY  = 3'd3,
		STATUS_LOCKED = 3'd4,
		STATUS_WAIT   = 3'd5
	} status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/phm_core.sv -----
// phm_core: keep-alive state, configuration registers and the per-poll update.
// Depends on phm_pkg. Produces the post-update result of the poll held upstream.
`default_nettype none

module phm_core #(
	parameter int TIME_WIDTH = phm_pkg::TimeWidthDef,
	parameter int FLAGS_WIDTH = phm_pkg::FlagsWidthDef,
	parameter int FULL_BIT = phm_pkg::FullBitDef,
	parameter int READY_BIT = phm_pkg::ReadyBitDef,
	parameter int HAS_BEEN_READY_BIT = phm_pkg::HasBeenReadyBitDef
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [phm_pkg::CfgIdxWidth-1:0]     cfg_index,
	input  wire logic [phm_pkg::CfgDataWidth-1:0]    cfg_wdata,
	input  wire logic                                step,
	input  wire logic                                op,
	input  wire logic [TIME_WIDTH-1:0]               time_now,
	input  wire logic [phm_pkg::IdWidth-1:0]         resp_id,
	input  wire logic [FLAGS_WIDTH-1:0]              resp_flags,
	output logic                                     send_ping,
	output logic [phm_pkg::IdWidth-1:0]              request_id,
	output logic [phm_pkg::RttWidth-1:0]             round_trip,
	output phm_pkg::status_t                         server_status,
	output logic [phm_pkg::CountWidth-1:0]           sent_count,
	output logic [phm_pkg::CountWidth-1:0]           lost_count,
	output logic [FLAGS_WIDTH-1:0]                   server_flags
);
	import phm_pkg::*;

	logic [CfgDataWidth-1:0] interval_q, timeout_q;

	logic                    awaiting_q, awaiting_n;
	logic [TIME_WIDTH-1:0]   last_time_q, last_time_n;
	logic [IdWidth-1:0]      id_q, id_n;
	logic [RttWidth-1:0]     rtt_q, rtt_n;
	reading_kind_t           kind_q, kind_n;
	logic [FLAGS_WIDTH-1:0]  flags_q, flags_n;
	logic [CountWidth-1:0]   sent_q, sent_n;
	logic [CountWidth-1:0]   lost_q, lost_n;

	logic [TIME_WIDTH-1:0]    elapsed;
	logic [FlagsMaxWidth-1:0] flags_ext;
	logic                     send_n;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= PingIntervalReset;
			timeout_q <= PingTimeoutReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REQ_INTERVAL:  interval_q <= cfg_wdata;
				CFG_REPLY_TIMEOUT: timeout_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign elapsed = time_now - last_time_q;

	always_comb begin
		awaiting_n = awaiting_q;
		last_time_n = last_time_q;
		id_n = id_q;
		rtt_n = rtt_q;
		kind_n = kind_q;
		flags_n = flags_q;
		sent_n = sent_q;
		lost_n = lost_q;
		send_n = 1'b0;
		if (awaiting_q) begin
			if (op) begin
				// only the matching reply closes the wait
				if (resp_id == id_q) begin
					awaiting_n = 1'b0;
					rtt_n = RttWidth'(elapsed);
					kind_n = KIND_MEASURED;
					last_time_n = time_now;
					flags_n = resp_flags;
				end
			end else if (elapsed >= TIME_WIDTH'(timeout_q)) begin
				// timeout keeps the request time as the event reference
				awaiting_n = 1'b0;
				kind_n = KIND_FAILED;
				lost_n = lost_q + 1'b1;
			end
		end else if (elapsed >= TIME_WIDTH'(interval_q)) begin
			id_n = id_q + 1'b1;
			last_time_n = time_now;
			awaiting_n = 1'b1;
			sent_n = sent_q + 1'b1;
			send_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			last_time_q <= '0;
			id_q <= '0;
			rtt_q <= '0;
			kind_q <= KIND_INIT;
			flags_q <= '0;
			sent_q <= '0;
			lost_q <= '0;
		end else if (step) begin
			awaiting_q <= awaiting_n;
			last_time_q <= last_time_n;
			id_q <= id_n;
			rtt_q <= rtt_n;
			kind_q <= kind_n;
			flags_q <= flags_n;
			sent_q <= sent_n;
			lost_q <= lost_n;
		end
	end

	// status decode on the updated state
	assign flags_ext = FlagsMaxWidth'(flags_n);

	always_comb begin
		case (kind_n)
			KIND_INIT:   server_status = STATUS_INIT;
			KIND_MEASURED: begin
				if (flags_ext[FULL_BIT])
					server_status = STATUS_FULL;
				else if (flags_ext[READY_BIT])
					server_status = STATUS_READY;
				else if (flags_ext[HAS_BEEN_READY_BIT])
					server_status = STATUS_LOCKED;
				else
					server_status = STATUS_WAIT;
			end
			default:     server_status = STATUS_FAILED;
		endcase
	end

	assign send_ping = send_n;
	assign request_id = id_n;
	assign round_trip = (kind_n == KIND_MEASURED) ? rtt_n : '0;
	assign sent_count = sent_n;
	assign lost_count = lost_n;
	assign server_flags = flags_n;

	// a request goes out only from idle
	a_send_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && send_n |-> !awaiting_q)
		else $error("request issued while a reply was pending");

	// sent counter moves by exactly one per request
	a_sent_count: assert property (@(posedge clk) disable iff (!arst_n)
		step && send_n |=> sent_q == $past(sent_q) + 1'b1)
		else $error("sent counter out of step with requests");

	// a loss is counted only when a pending wait ends without a reply
	a_loss_ends_wait: assert property (@(posedge clk) disable iff (!arst_n)
		step && (lost_n != lost_q) |-> awaiting_q && !awaiting_n && !op)
		else $error("loss counted outside a timeout");

endmodule

`default_nettype wire

// ----- hw/rtl/ping_heartbeat_monitor.sv -----
// Ping heartbeat monitor: a poll passes the input register, then the result register;
// one poll per cycle sustained while the output does not stall, set by the single update
// pass in phm_core. Output stall back-pressures the input only when both registers hold
// work. Asynchronous active-low reset clears the core state, counters and valid flags, sets
// the request interval to 1000, the reply timeout to 4000, and leaves both channels empty.
`default_nettype none

module ping_heartbeat_monitor #(
	parameter int TIME_WIDTH = phm_pkg::TimeWidthDef,
	parameter int FLAGS_WIDTH = phm_pkg::FlagsWidthDef,
	parameter int FULL_BIT = phm_pkg::FullBitDef,
	parameter int READY_BIT = phm_pkg::ReadyBitDef,
	parameter int HAS_BEEN_READY_BIT = phm_pkg::HasBeenReadyBitDef
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration write port
	input  wire logic                             cfg_we,
	input  wire logic [phm_pkg::CfgIdxWidth-1:0]  cfg_index,
	input  wire logic [phm_pkg::CfgDataWidth-1:0] cfg_wdata,
	// poll channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             op,
	input  wire logic [TIME_WIDTH-1:0]            time_now,
	input  wire logic [phm_pkg::IdWidth-1:0]      resp_id,
	input  wire logic [FLAGS_WIDTH-1:0]           resp_flags,
	// result channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  send_ping,
	output logic [phm_pkg::IdWidth-1:0]           request_id,
	output logic [phm_pkg::RttWidth-1:0]          round_trip,
	output logic [2:0]                            server_status,
	output logic [phm_pkg::CountWidth-1:0]        sent_count,
	output logic [phm_pkg::CountWidth-1:0]        lost_count,
	output logic [FLAGS_WIDTH-1:0]                server_flags
);
	import phm_pkg::*;

	// Input register: one poll transaction waiting for the update pass.
	logic                   valid_s1;
	logic                   op_s1;
	logic [TIME_WIDTH-1:0]  time_s1;
	logic [IdWidth-1:0]     resp_id_s1;
	logic [FLAGS_WIDTH-1:0] resp_flags_s1;

	// Result register.
	logic                   valid_s2;

	logic                   advance;
	logic                   in_take;

	logic                   send_c;
	logic [IdWidth-1:0]     req_id_c;
	logic [RttWidth-1:0]    rtt_c;
	status_t                status_c;
	logic [CountWidth-1:0]  sent_c, lost_c;
	logic [FLAGS_WIDTH-1:0] flags_c;

	// The held poll is processed when the result register is empty or is being
	// drained this cycle; state in phm_core updates on that same edge.
	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1 <= op;
			time_s1 <= time_now;
			resp_id_s1 <= resp_id;
			resp_flags_s1 <= resp_flags;
		end
	end

	phm_core #(
		.TIME_WIDTH(TIME_WIDTH),
		.FLAGS_WIDTH(FLAGS_WIDTH),
		.FULL_BIT(FULL_BIT),
		.READY_BIT(READY_BIT),
		.HAS_BEEN_READY_BIT(HAS_BEEN_READY_BIT)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.step(advance),
		.op(op_s1),
		.time_now(time_s1),
		.resp_id(resp_id_s1),
		.resp_flags(resp_flags_s1),
		.send_ping(send_c),
		.request_id(req_id_c),
		.round_trip(rtt_c),
		.server_status(status_c),
		.sent_count(sent_c),
		.lost_count(lost_c),
		.server_flags(flags_c)
	);

	// Result register: filled on advance, emptied when the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			send_ping <= send_c;
			request_id <= req_id_c;
			round_trip <= rtt_c;
			server_status <= status_c;
			sent_count <= sent_c;
			lost_count <= lost_c;
			server_flags <= flags_c;
		end
	end

	assign out_valid = valid_s2;

	// back-pressure only when both stages are occupied and the output is stuck
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a blocked result");

	// a drained result with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_stall && !advance |=> !valid_s2)
		else $error("result transaction repeated");

	// every processed poll shows up as a result on the next cycle
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("processed poll produced no result");

endmodule

`default_nettype wire
